>>> hdl/sdf_pkg.sv
// Shared constants for the serial frame deframer: sync bytes, parser
// phase codes and result event codes. No dependencies.
`timescale 1ns / 1ps

package sdf_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned LEN_W   = 16;
   localparam int unsigned EVENT_W = 2;
   localparam int unsigned PHASE_W = 3;

   localparam logic [BYTE_W-1:0] SYNC_A = 8'h55;
   localparam logic [BYTE_W-1:0] SYNC_B = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC_C = 8'h42;

   localparam logic [LEN_W-1:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [LEN_W-1:0] COUNT_MAX     = 16'hFFFF;

   // parser phases
   localparam logic [PHASE_W-1:0] PH_SYNC_A = 3'd0;
   localparam logic [PHASE_W-1:0] PH_SYNC_B = 3'd1;
   localparam logic [PHASE_W-1:0] PH_SYNC_C = 3'd2;
   localparam logic [PHASE_W-1:0] PH_LEN_LO = 3'd3;
   localparam logic [PHASE_W-1:0] PH_LEN_HI = 3'd4;
   localparam logic [PHASE_W-1:0] PH_DATA   = 3'd5;

   // input kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // result events
   localparam logic [EVENT_W-1:0] EV_DATA  = 2'd0;
   localparam logic [EVENT_W-1:0] EV_EMPTY = 2'd1;
   localparam logic [EVENT_W-1:0] EV_SYNC  = 2'd2;
   localparam logic [EVENT_W-1:0] EV_TRUNC = 2'd3;

endpackage

>>> hdl/serial_frame_deframer_unit.sv
// Serial frame deframer top level: parser state, timeout counter and
// result register. Depends on sdf_pkg.
`timescale 1ns / 1ps

//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | req_kind, req_byte_in
//  rsp     | out       | rsp_valid / rsp_stall | rsp_event_res .. rsp_received_count
//  csr     | in        | csr_wr_en             | csr_wr_data (idle timeout ticks)
//
// One item per cycle while req_stall is low: each transfer on req is parsed
// in the cycle it arrives and its result, if any, is in the rsp register on
// the next cycle.
// req_stall is raised only while a held result waits under rsp_stall.
// Reset is synchronous, active high; it clears the parser and loads the
// idle timeout with 1000 ticks. Frames use sync 55 AA 42 and a 16-bit
// little-endian length.

module serial_frame_deframer_unit
   import sdf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // input channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_kind,
   input  logic [BYTE_W-1:0]   req_byte_in,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [EVENT_W-1:0]  rsp_event_res,
   output logic [BYTE_W-1:0]   rsp_payload_byte,
   output logic                rsp_last,
   output logic [LEN_W-1:0]    rsp_expected_length,
   output logic [LEN_W-1:0]    rsp_received_count,
   // configuration
   input  logic                csr_wr_en,
   input  logic [LEN_W-1:0]    csr_wr_data
);

   // parser state
   logic [PHASE_W-1:0] phase_ff,     phase_in;
   logic [LEN_W-1:0]   frame_len_ff, frame_len_in;
   logic [LEN_W-1:0]   rcv_cnt_ff,   rcv_cnt_in;
   logic [LEN_W-1:0]   idle_cnt_ff,  idle_cnt_in;
   logic [LEN_W-1:0]   timeout_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [EVENT_W-1:0] ev_ff;
   logic [BYTE_W-1:0]  pbyte_ff;
   logic               last_ff;
   logic [LEN_W-1:0]   exp_len_ff;
   logic [LEN_W-1:0]   rcv_out_ff;

   // result of the current item
   logic               res_valid;
   logic [EVENT_W-1:0] res_ev;
   logic [BYTE_W-1:0]  res_byte;
   logic               res_last;
   logic [LEN_W-1:0]   res_exp;
   logic [LEN_W-1:0]   res_rcv;

   logic               req_accept;
   logic               in_frame;
   logic [LEN_W-1:0]   idle_inc;
   logic [LEN_W-1:0]   rcv_inc;
   logic [LEN_W-1:0]   len_full;

   // the held result blocks new items only while it is stalled
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   // unused phase codes behave as the first sync phase
   assign in_frame = (phase_ff == PH_SYNC_B) || (phase_ff == PH_SYNC_C) ||
                     (phase_ff == PH_LEN_LO) || (phase_ff == PH_LEN_HI) ||
                     (phase_ff == PH_DATA);

   assign idle_inc = (idle_cnt_ff < COUNT_MAX) ? idle_cnt_ff + 1'b1 : idle_cnt_ff;
   assign rcv_inc  = rcv_cnt_ff + 1'b1;
   assign len_full = {req_byte_in, frame_len_ff[BYTE_W-1:0]};

   always_comb begin
      phase_in     = phase_ff;
      frame_len_in = frame_len_ff;
      rcv_cnt_in   = rcv_cnt_ff;
      idle_cnt_in  = idle_cnt_ff;
      res_valid    = 1'b0;
      res_ev       = EV_DATA;
      res_byte     = '0;
      res_last     = 1'b0;
      res_exp      = '0;
      res_rcv      = '0;

      if (req_kind == KIND_TICK) begin
         if (in_frame) begin
            idle_cnt_in = idle_inc;
            // a zero timeout acts as one since idle_inc is at least one here
            if (idle_inc >= timeout_ff) begin
               res_valid = 1'b1;
               res_ev    = EV_TRUNC;
               if (phase_ff == PH_DATA) begin
                  res_exp = frame_len_ff;
                  res_rcv = rcv_cnt_ff;
               end
               phase_in     = PH_SYNC_A;
               frame_len_in = '0;
               rcv_cnt_in   = '0;
               idle_cnt_in  = '0;
            end
         end else begin
            idle_cnt_in = '0;
         end
      end else begin
         idle_cnt_in = '0;
         case (phase_ff)
            PH_SYNC_B: begin
               if (req_byte_in == SYNC_B) begin
                  phase_in = PH_SYNC_C;
               end else begin
                  res_valid    = 1'b1;
                  res_ev       = EV_SYNC;
                  res_byte     = req_byte_in;
                  phase_in     = PH_SYNC_A;
                  frame_len_in = '0;
                  rcv_cnt_in   = '0;
               end
            end
            PH_SYNC_C: begin
               if (req_byte_in == SYNC_C) begin
                  phase_in = PH_LEN_LO;
               end else begin
                  res_valid    = 1'b1;
                  res_ev       = EV_SYNC;
                  res_byte     = req_byte_in;
                  phase_in     = PH_SYNC_A;
                  frame_len_in = '0;
                  rcv_cnt_in   = '0;
               end
            end
            PH_LEN_LO: begin
               frame_len_in = {{(LEN_W-BYTE_W){1'b0}}, req_byte_in};
               phase_in     = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               rcv_cnt_in = '0;
               if (len_full == '0) begin
                  res_valid    = 1'b1;
                  res_ev       = EV_EMPTY;
                  phase_in     = PH_SYNC_A;
                  frame_len_in = '0;
               end else begin
                  frame_len_in = len_full;
                  phase_in     = PH_DATA;
               end
            end
            PH_DATA: begin
               res_valid = 1'b1;
               res_ev    = EV_DATA;
               res_byte  = req_byte_in;
               if (rcv_inc >= frame_len_ff) begin
                  res_last     = 1'b1;
                  phase_in     = PH_SYNC_A;
                  frame_len_in = '0;
                  rcv_cnt_in   = '0;
               end else begin
                  rcv_cnt_in = rcv_inc;
               end
            end
            default: begin
               if (req_byte_in == SYNC_A) begin
                  phase_in = PH_SYNC_B;
               end else begin
                  res_valid = 1'b1;
                  res_ev    = EV_SYNC;
                  res_byte  = req_byte_in;
                  phase_in  = PH_SYNC_A;
               end
            end
         endcase
      end
   end

   // a result stays until taken; a new one loads only on an accepted item
   assign rsp_valid_in = (req_accept & res_valid) | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SYNC_A;
         frame_len_ff <= '0;
         rcv_cnt_ff   <= '0;
         idle_cnt_ff  <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            phase_ff     <= phase_in;
            frame_len_ff <= frame_len_in;
            rcv_cnt_ff   <= rcv_cnt_in;
            idle_cnt_ff  <= idle_cnt_in;
         end
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept & res_valid) begin
         ev_ff      <= res_ev;
         pbyte_ff   <= res_byte;
         last_ff    <= res_last;
         exp_len_ff <= res_exp;
         rcv_out_ff <= res_rcv;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_res       = ev_ff;
   assign rsp_payload_byte    = pbyte_ff;
   assign rsp_last            = last_ff;
   assign rsp_expected_length = exp_len_ff;
   assign rsp_received_count  = rcv_out_ff;

endmodule

>>> hdl/sdf_checker.sv
// Port-level checks for the serial frame deframer, bound to the top level.
// Depends on sdf_pkg and serial_frame_deframer_unit.
`timescale 1ns / 1ps

module sdf_checker
   import sdf_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [EVENT_W-1:0] rsp_event_res,
   input logic [BYTE_W-1:0]  rsp_payload_byte,
   input logic               rsp_last,
   input logic [LEN_W-1:0]   rsp_expected_length,
   input logic [LEN_W-1:0]   rsp_received_count
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_res) &&
      $stable(rsp_payload_byte) && $stable(rsp_last) &&
      $stable(rsp_expected_length) && $stable(rsp_received_count))
      else $error("rsp changed while stalled");

   // reset leaves no result pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // last flag only on payload bytes
   a_last_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_event_res == EV_DATA)
      else $error("last on non-data event");

   // counts appear only in truncation reports
   a_counts_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EV_TRUNC |->
      rsp_expected_length == '0 && rsp_received_count == '0)
      else $error("counts on non-truncation event");

   // a truncated frame is short of its length
   a_trunc_short: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_TRUNC |->
      rsp_received_count < rsp_expected_length ||
      (rsp_expected_length == '0 && rsp_received_count == '0))
      else $error("truncation count not below length");

endmodule

bind serial_frame_deframer_unit sdf_checker u_sdf_checker (.*);

>>> dv/serial_frame_deframer_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for serial_frame_deframer_unit: a scoreboard class predicts every
// event from accepted transfers and checks the rsp channel against it.
// Depends on sdf_pkg and the serial_frame_deframer_unit RTL.

module serial_frame_deframer_unit_tb;
   import sdf_pkg::*;

   // cycles with no transfer on either channel before the run is declared hung
   localparam int unsigned STUCK_LIMIT  = 1000;
   // counted transfers per random phase; five phases give about 400
   localparam int unsigned PHASE_ITEMS  = 80;
   // mismatch lines printed before the report goes quiet (counting goes on)
   localparam int unsigned REPORT_CAP   = 50;
   localparam int unsigned HEADER_BYTES = 5;

   typedef struct packed {
      logic [EVENT_W-1:0] ev;
      logic [BYTE_W-1:0]  data;
      logic               last;
      logic [LEN_W-1:0]   exp_len;
      logic [LEN_W-1:0]   rcv_cnt;
   } frame_event_type;

   // -------------------------------------------------------------------------
   // Scoreboard: its own copy of the parser state and the timeout register,
   // plus the queue of events the unit still owes us.
   // -------------------------------------------------------------------------
   class deframe_scoreboard_type;
      logic [PHASE_W-1:0] stage;
      logic [LEN_W-1:0]   frame_len;
      logic [LEN_W-1:0]   rx_count;
      logic [LEN_W-1:0]   idle_ticks;
      logic [LEN_W-1:0]   timeout_ticks;
      frame_event_type    pending_events[$];
      int unsigned        error_count;

      function new();
         timeout_ticks = TIMEOUT_RESET;
         error_count   = 0;
         rearm();
      endfunction

      // back to hunting for the first sync byte
      function void rearm();
         stage      = PH_SYNC_A;
         frame_len  = '0;
         rx_count   = '0;
         idle_ticks = '0;
      endfunction

      function void post(logic [EVENT_W-1:0] ev, logic [BYTE_W-1:0] data, logic last,
                         logic [LEN_W-1:0] exp_len, logic [LEN_W-1:0] rcv_cnt);
         frame_event_type e;
         e.ev      = ev;
         e.data    = data;
         e.last    = last;
         e.exp_len = exp_len;
         e.rcv_cnt = rcv_cnt;
         pending_events.push_back(e);
      endfunction

      // Note one accepted req transfer. Returns 0 for an idle tick that the
      // parser ignores while hunting, 1 otherwise.
      function bit absorb_transfer(logic kind, logic [BYTE_W-1:0] b);
         if (kind == KIND_TICK) begin
            if (stage == PH_SYNC_A || stage > PH_DATA) begin
               idle_ticks = '0;
               return 1'b0;
            end
            if (idle_ticks != COUNT_MAX)
               idle_ticks++;
            // a zero register compares like one: the first tick strikes
            if (idle_ticks >= timeout_ticks) begin
               if (stage == PH_DATA)
                  post(EV_TRUNC, '0, 1'b0, frame_len, rx_count);
               else
                  post(EV_TRUNC, '0, 1'b0, '0, '0);
               rearm();
            end
            return 1'b1;
         end

         idle_ticks = '0;
         case (stage)
            PH_SYNC_B: begin
               if (b == SYNC_B) begin
                  stage = PH_SYNC_C;
               end else begin
                  rearm();
                  post(EV_SYNC, b, 1'b0, '0, '0);
               end
            end
            PH_SYNC_C: begin
               if (b == SYNC_C) begin
                  stage = PH_LEN_LO;
               end else begin
                  rearm();
                  post(EV_SYNC, b, 1'b0, '0, '0);
               end
            end
            PH_LEN_LO: begin
               frame_len = {8'h00, b};
               stage     = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               frame_len = {b, frame_len[7:0]};
               rx_count  = '0;
               if (frame_len == '0) begin
                  rearm();
                  post(EV_EMPTY, '0, 1'b0, '0, '0);
               end else begin
                  stage = PH_DATA;
               end
            end
            PH_DATA: begin
               rx_count++;
               if (rx_count >= frame_len) begin
                  rearm();
                  post(EV_DATA, b, 1'b1, '0, '0);
               end else begin
                  post(EV_DATA, b, 1'b0, '0, '0);
               end
            end
            default: begin
               stage = PH_SYNC_A;
               if (b == SYNC_A)
                  stage = PH_SYNC_B;
               else
                  post(EV_SYNC, b, 1'b0, '0, '0);
            end
         endcase
         return 1'b1;
      endfunction

      task flag_mismatch(string what);
         if (error_count < REPORT_CAP)
            $display("%0t ERROR %s", $time, what);
         error_count++;
      endtask

      task match_result(frame_event_type got);
         frame_event_type want;
         if (pending_events.size() == 0) begin
            flag_mismatch($sformatf("rsp transfer with nothing pending: event %0d byte %02h",
                                    got.ev, got.data));
            return;
         end
         want = pending_events.pop_front();
         if (got.ev != want.ev)
            flag_mismatch($sformatf("event_res %0d, want %0d", got.ev, want.ev));
         if (got.data != want.data)
            flag_mismatch($sformatf("payload_byte %02h, want %02h", got.data, want.data));
         if (got.last != want.last)
            flag_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
         if (got.exp_len != want.exp_len)
            flag_mismatch($sformatf("expected_length %0d, want %0d",
                                    got.exp_len, want.exp_len));
         if (got.rcv_cnt != want.rcv_cnt)
            flag_mismatch($sformatf("received_count %0d, want %0d",
                                    got.rcv_cnt, want.rcv_cnt));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup
   // -------------------------------------------------------------------------
   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_kind;
   logic [BYTE_W-1:0]  req_byte_in;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [EVENT_W-1:0] rsp_event_res;
   logic [BYTE_W-1:0]  rsp_payload_byte;
   logic               rsp_last;
   logic [LEN_W-1:0]   rsp_expected_length;
   logic [LEN_W-1:0]   rsp_received_count;
   logic               csr_wr_en;
   logic [LEN_W-1:0]   csr_wr_data;

   // percent of cycles the sender idles / the receiver stalls
   int unsigned        gap_pct;
   int unsigned        hold_pct;
   // req transfers that the parser acts on (hunting ticks excluded)
   int unsigned        counted_items;
   deframe_scoreboard_type sb;

   serial_frame_deframer_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_byte_in         (req_byte_in),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_event_res       (rsp_event_res),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_last            (rsp_last),
      .rsp_expected_length (rsp_expected_length),
      .rsp_received_count  (rsp_received_count),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: stall decided at each falling edge, so rsp_stall is settled
   // well before the rising edge where the transfer is judged.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(99) < hold_pct);
      end
   end

   // Every rsp transfer is checked against the oldest pending event.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.match_result(frame_event_type'({rsp_event_res, rsp_payload_byte, rsp_last,
                                            rsp_expected_length, rsp_received_count}));
   end

   // Watchdog: a hung handshake shows up as a long run of cycles without a
   // transfer on either channel.
   initial begin
      int unsigned stuck;
      stuck = 0;
      while (stuck < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck = 0;
         else
            stuck++;
      end
      $display("serial_frame_deframer_unit verification failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Driving tasks. Each starts and ends at a falling edge.
   // -------------------------------------------------------------------------

   // One req transfer, after a random number of idle cycles. valid stays up
   // between back-to-back transfers; only the payload moves.
   task automatic send_item(input logic kind, input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_byte_in <= b;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (sb.absorb_transfer(kind, b))
         counted_items++;
      @(negedge clock);
   endtask

   // Idle ticks until the parser gives up on the partial frame.
   task automatic send_ticks_to_hunt();
      while (sb.stage != PH_SYNC_A)
         send_item(KIND_TICK, 8'($urandom));
   endtask

   // Stop sending and let every pending event drain, plus the pipeline
   // latency for a last transfer that produced nothing.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (sb.pending_events.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_timeout(input logic [LEN_W-1:0] ticks);
      wait_quiet();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ticks;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.timeout_ticks = ticks;
   endtask

   // The first `cut` bytes of a frame: sync, length low/high, then random
   // payload. cut = len + HEADER_BYTES sends the whole frame. With tick_pct
   // set, short runs of idle ticks land between bytes; if they time the frame
   // out the rest is dropped.
   task automatic send_frame(input logic [LEN_W-1:0] len, input int unsigned cut,
                             input int unsigned tick_pct);
      logic [BYTE_W-1:0] b;
      for (int unsigned k = 0; k < cut; k++) begin
         if (k != 0 && $urandom_range(99) < tick_pct) begin
            repeat ($urandom_range(1, 3)) send_item(KIND_TICK, 8'($urandom));
            if (sb.stage == PH_SYNC_A)
               return;
         end
         case (k)
            0:       b = SYNC_A;
            1:       b = SYNC_B;
            2:       b = SYNC_C;
            3:       b = len[7:0];
            4:       b = len[15:8];
            default: b = 8'($urandom);
         endcase
         send_item(KIND_BYTE, b);
      end
   endtask

   // One random burst: mostly whole frames, then abandoned frames, broken
   // sync sequences and raw noise.
   task automatic send_burst();
      int unsigned       pick;
      int unsigned       size_pick;
      int unsigned       span;
      logic [LEN_W-1:0]  len;
      logic [BYTE_W-1:0] nb;
      pick      = $urandom_range(99);
      size_pick = $urandom_range(99);
      if (size_pick < 10)
         len = '0;
      else if (size_pick < 90)
         len = LEN_W'($urandom_range(1, 8));
      else
         len = LEN_W'($urandom_range(9, 40));

      // now and then the sender holds off until the unit has caught up
      if ($urandom_range(99) < 3)
         wait_quiet();

      if (pick < 60) begin
         send_frame(len, len + HEADER_BYTES, 5);
      end else if (pick < 75) begin
         // partial frame left to time out, sometimes with a huge length
         if (pick < 68)
            len = LEN_W'($urandom);
         span = HEADER_BYTES + ((len < 8) ? len : 8) - 1;
         send_frame(len, $urandom_range(1, span), 0);
         send_ticks_to_hunt();
      end else if (pick < 88) begin
         send_item(KIND_BYTE, SYNC_A);
         if (pick >= 81)
            send_item(KIND_BYTE, SYNC_B);
         send_item(KIND_BYTE, 8'($urandom));
      end else begin
         repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(7))
               0:       nb = SYNC_A;
               1:       nb = SYNC_B;
               2:       nb = SYNC_C;
               default: nb = 8'($urandom);
            endcase
            send_item(1'($urandom), nb);
         end
      end
   endtask

   task automatic run_phase(input int unsigned gap, input int unsigned hold,
                            input logic [LEN_W-1:0] timeout);
      int unsigned target;
      write_timeout(timeout);
      gap_pct  = gap;
      hold_pct = hold;
      target   = counted_items + PHASE_ITEMS;
      while (counted_items < target)
         send_burst();
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      sb            = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_kind      = KIND_BYTE;
      req_byte_in   = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      gap_pct       = 0;
      hold_pct      = 0;
      counted_items = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part with a short timeout.
      write_timeout(16'd2);

      // Max-length frame cut after one payload byte: truncation must report
      // 65535 expected, 1 received.
      send_frame(16'hFFFF, HEADER_BYTES + 1, 0);
      send_ticks_to_hunt();

      send_item(KIND_TICK, 8'hFF);          // tick while hunting: ignored
      send_item(KIND_BYTE, 8'h00);          // bad first sync byte
      send_item(KIND_BYTE, SYNC_A);         // bad second sync byte
      send_item(KIND_BYTE, 8'h13);
      send_item(KIND_BYTE, SYNC_A);         // bad third sync byte
      send_item(KIND_BYTE, SYNC_B);
      send_item(KIND_BYTE, 8'hFF);
      send_frame(16'h0000, HEADER_BYTES, 0); // zero length: empty-frame event
      send_frame(16'h0002, HEADER_BYTES, 0); // two payload bytes at the extremes
      send_item(KIND_BYTE, 8'h00);
      send_item(KIND_BYTE, 8'hFF);
      send_item(KIND_BYTE, SYNC_A);         // timeout before the payload
      send_ticks_to_hunt();

      // Random part: idling mixes and timeout settings, zero among them.
      run_phase(0, 0, 16'd3);
      run_phase(54, 0, 16'd1);
      run_phase(0, 54, 16'd0);
      run_phase(13, 13, LEN_W'($urandom_range(2, 20)));
      run_phase(0, 0, 16'd8);

      // Largest timeout: a whole frame with idle ticks between its bytes
      // must come through without truncation.
      write_timeout(COUNT_MAX);
      gap_pct  = 0;
      hold_pct = 0;
      send_frame(16'h0010, HEADER_BYTES + 16, 30);

      // Drain, then leave room for any stray extra result to show up.
      wait_quiet();
      repeat (8) @(negedge clock);
      if (sb.error_count == 0)
         $display("serial_frame_deframer_unit verification clean");
      else
         $display("serial_frame_deframer_unit verification failed");
      $finish;
   end

endmodule

>>> sim.f
hdl/sdf_pkg.sv
hdl/serial_frame_deframer_unit.sv
hdl/sdf_checker.sv
dv/serial_frame_deframer_unit_tb.sv
